// ===== sv/marf_pkg.sv =====
// marf_pkg: shared constants, codes and types of the multichannel audio ring fifo
// used by the channel interfaces and by every module of the block
package marf_pkg;

    // ring geometry
    localparam int DEPTH_FRAMES = 4096;
    localparam int MAX_CHANNELS = 8;
    localparam int FRAME_W      = $clog2(DEPTH_FRAMES);
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int ADDR_W       = $clog2(DEPTH_FRAMES * MAX_CHANNELS);
    localparam int MEM_WORDS    = DEPTH_FRAMES * MAX_CHANNELS;

    // item field widths
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 32;
    localparam int SEL_W    = 3;
    localparam int SLOT_W   = 11;
    localparam int GRANT_W  = 12;
    localparam int FILL_W   = 12;

    // configuration registers
    localparam int CC_W       = 4;
    localparam int PERIOD_W   = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // effective channel count and wide compare widths
    localparam int NCH_W  = (CH_W + 1 > CC_W) ? CH_W + 1 : CC_W;
    localparam int WIDE_W = FRAME_W + GRANT_W;
    localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // reset values of the configuration registers
    localparam logic [CC_W-1:0]     CC_RESET     = CC_W'(2);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_PERIOD = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_PERIOD_FRAMES = 1'b1
    } t_cfg_reg;

    // status fields of one result item, everything but the sample word
    typedef struct packed {
        logic               accepted;
        logic               sample_valid;
        logic [GRANT_W-1:0] granted_frames;
        logic               underrun;
        logic [FILL_W-1:0]  fill_frames;
        logic               half_out;
    } t_res;

    // one classified item handed from front to back
    typedef struct packed {
        logic                mem_we;
        logic                mem_re;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] wdata;
        t_res                res;
    } t_cmd;

endpackage

// ===== sv/marf_in_if.sv =====
// marf_in_if: valid/ready channel carrying one input item
// field widths follow marf_pkg
interface marf_in_if;
    logic                             valid;
    logic                             ready;
    logic [marf_pkg::OP_W-1:0]        operation;
    logic [marf_pkg::SAMPLE_W-1:0]    sample_in;
    logic [marf_pkg::SEL_W-1:0]       channel_sel;
    logic [marf_pkg::SLOT_W-1:0]      slot_sel;
    logic                             buffer_half;

    modport source (
        output valid, operation, sample_in, channel_sel, slot_sel, buffer_half,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_in, channel_sel, slot_sel, buffer_half,
        output ready
    );
endinterface

// ===== sv/marf_out_if.sv =====
// marf_out_if: valid/ready channel carrying one result item
// field widths follow marf_pkg
interface marf_out_if;
    logic                             valid;
    logic                             ready;
    logic                             accepted;
    logic [marf_pkg::SAMPLE_W-1:0]    sample_out;
    logic                             sample_valid;
    logic [marf_pkg::GRANT_W-1:0]     granted_frames;
    logic                             underrun;
    logic [marf_pkg::FILL_W-1:0]      fill_frames;
    logic                             half_out;

    modport source (
        output valid, accepted, sample_out, sample_valid, granted_frames,
               underrun, fill_frames, half_out,
        input  ready
    );
    modport sink (
        input  valid, accepted, sample_out, sample_valid, granted_frames,
               underrun, fill_frames, half_out,
        output ready
    );
endinterface

// ===== sv/marf_front.sv =====
// marf_front: accepts items, keeps ring pointers, grant and config registers
// classifies each item into a memory command plus status; depends on marf_pkg
module marf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    marf_in_if.sink                          i_in,
    input  logic                             i_cfg_we,
    input  logic [marf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [marf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_q_ready,
    output logic                             o_q_push,
    output marf_pkg::t_cmd                   o_q_cmd
);
    import marf_pkg::*;

    logic [CC_W-1:0]     r_cc;
    logic [PERIOD_W-1:0] r_period;
    logic [FRAME_W-1:0]  r_wpos, n_wpos;
    logic [FRAME_W-1:0]  r_rpos, n_rpos;
    logic [CH_W-1:0]     r_wcp, n_wcp;
    logic                r_dropping, n_dropping;
    logic [GRANT_W-1:0]  r_grant, n_grant;
    logic                r_underrun, n_underrun;
    logic                r_half, n_half;

    logic [NCH_W-1:0]    cc_x;
    logic [NCH_W-1:0]    nch;
    logic [FRAME_W-1:0]  used;
    logic                drop;
    logic                last_ch;
    logic [FRAME_W-1:0]  rpos_p;
    logic [FRAME_W-1:0]  used_p;
    logic [WIDE_W-1:0]   grant_w;
    logic                chan_ok;
    logic                in_grant;
    logic                in_period;
    logic [FRAME_W-1:0]  frame_sel;
    logic [CH_W-1:0]     ch_sel;
    logic [FRAME_W-1:0]  n_used;
    logic [WIDE_W-1:0]   waiting;
    logic                accept;
    t_op                 op;

    assign accept     = i_in.valid && i_q_ready;
    assign i_in.ready = i_q_ready;
    assign o_q_push   = accept;
    assign op         = t_op'(i_in.operation);

    // effective channel count, clamped to the supported range
    assign cc_x = NCH_W'(r_cc);
    always_comb begin
        if (cc_x < NCH_W'(2)) begin
            nch = NCH_W'(2);
        end else if (cc_x > NCH_W'(MAX_CHANNELS)) begin
            nch = NCH_W'(MAX_CHANNELS);
        end else begin
            nch = cc_x;
        end
    end

    // write side: drop decision is taken at the first channel of a frame
    assign used    = r_wpos - r_rpos;
    assign drop    = (r_wcp == '0) ? (used >= FRAME_W'(DEPTH_FRAMES - 1)) : r_dropping;
    assign last_ch = (NCH_W'(r_wcp) + NCH_W'(1)) >= nch;

    // period start: release old grant, then grant up to one period
    assign rpos_p  = r_rpos + FRAME_W'(r_grant);
    assign used_p  = r_wpos - rpos_p;
    assign grant_w = (WIDE_W'(used_p) < WIDE_W'(r_period)) ? WIDE_W'(used_p)
                                                           : WIDE_W'(r_period);

    // read side checks
    assign chan_ok   = NCH_W'(i_in.channel_sel) < nch;
    assign in_grant  = GRANT_W'(i_in.slot_sel) < r_grant;
    assign in_period = PERIOD_W'(i_in.slot_sel) < r_period;

    // next state
    always_comb begin
        n_wpos     = r_wpos;
        n_rpos     = r_rpos;
        n_wcp      = r_wcp;
        n_dropping = r_dropping;
        n_grant    = r_grant;
        n_underrun = r_underrun;
        n_half     = r_half;
        if (accept) begin
            case (op)
                OP_WRITE: begin
                    if (last_ch) begin
                        n_wcp      = '0;
                        n_dropping = 1'b0;
                        if (!drop) begin
                            n_wpos = r_wpos + FRAME_W'(1);
                        end
                    end else begin
                        n_wcp      = r_wcp + CH_W'(1);
                        n_dropping = drop;
                    end
                end
                OP_PERIOD: begin
                    n_rpos     = rpos_p;
                    n_grant    = GRANT_W'(grant_w);
                    n_underrun = (used_p == '0);
                    n_half     = i_in.buffer_half;
                end
                default: begin
                end
            endcase
        end
    end

    // fill level after the item, beyond the grant, saturated
    assign n_used  = n_wpos - n_rpos;
    assign waiting = (WIDE_W'(n_used) >= WIDE_W'(n_grant))
                   ? (WIDE_W'(n_used) - WIDE_W'(n_grant)) : '0;

    // memory address of the word touched by this item
    assign frame_sel = (op == OP_WRITE) ? r_wpos : (r_rpos + FRAME_W'(i_in.slot_sel));
    assign ch_sel    = (op == OP_WRITE) ? r_wcp  : CH_W'(i_in.channel_sel);

    // command for the back end
    always_comb begin
        o_q_cmd                    = '0;
        o_q_cmd.addr               = ADDR_W'(frame_sel) * ADDR_W'(MAX_CHANNELS)
                                   + ADDR_W'(ch_sel);
        o_q_cmd.wdata              = i_in.sample_in;
        o_q_cmd.res.granted_frames = n_grant;
        o_q_cmd.res.underrun       = n_underrun;
        o_q_cmd.res.half_out       = n_half;
        o_q_cmd.res.fill_frames    = (waiting > WIDE_W'(FILL_MAX)) ? FILL_MAX
                                                                   : FILL_W'(waiting);
        case (op)
            OP_WRITE: begin
                o_q_cmd.mem_we       = !drop;
                o_q_cmd.res.accepted = !drop;
            end
            OP_READ: begin
                o_q_cmd.mem_re           = chan_ok && !r_underrun && in_grant;
                o_q_cmd.res.sample_valid = chan_ok && (r_underrun ? in_period : in_grant);
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc     <= CC_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_CHANNEL_COUNT: r_cc     <= CC_W'(i_cfg_data);
                CFG_PERIOD_FRAMES: r_period <= PERIOD_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // ring state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos     <= '0;
            r_rpos     <= '0;
            r_wcp      <= '0;
            r_dropping <= 1'b0;
            r_grant    <= '0;
            r_underrun <= 1'b1;
            r_half     <= 1'b0;
        end else begin
            r_wpos     <= n_wpos;
            r_rpos     <= n_rpos;
            r_wcp      <= n_wcp;
            r_dropping <= n_dropping;
            r_grant    <= n_grant;
            r_underrun <= n_underrun;
            r_half     <= n_half;
        end
    end

    // a dropped frame is always in progress past its first channel
    a_drop_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> (r_wcp != '0))
        else $error("frame drop flag set at frame boundary");

    // an underrun period never carries a grant
    a_underrun_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_underrun |-> (r_grant == '0))
        else $error("grant present during underrun");

endmodule

// ===== sv/marf_queue.sv =====
// marf_queue: short command queue between front and back
// lets either side stall on its own; depends on marf_pkg
module marf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  marf_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output marf_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import marf_pkg::*;

    t_cmd             r_slot [Q_DEPTH];
    logic [QP_W-1:0]  r_wptr;
    logic [QP_W-1:0]  r_rptr;
    logic [QC_W-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != QC_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wptr + QP_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rptr + QP_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QC_W'(1);
                2'b01:   r_count <= r_count - QC_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // occupancy never exceeds the queue depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(Q_DEPTH))
        else $error("queue occupancy out of range");

    // pointer distance matches occupancy while not full
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < QC_W'(Q_DEPTH)) |-> (QP_W'(r_wptr - r_rptr) == QP_W'(r_count)))
        else $error("queue pointers disagree with occupancy");

endmodule

// ===== sv/marf_back.sv =====
// marf_back: sample memory and result output register
// executes queued write and read commands in order; depends on marf_pkg
module marf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  marf_pkg::t_cmd  i_q_cmd,
    output logic            o_pop,
    marf_out_if.source      o_out
);
    import marf_pkg::*;

    logic [SAMPLE_W-1:0] r_ring [MEM_WORDS];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_s1_valid;
    logic                r_s1_rd;
    t_res                r_s1_res;

    // take the next command when the output register is free or draining
    assign o_pop = i_q_valid && (!r_s1_valid || o_out.ready);

    // sample memory: one write or one registered read per item
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_cmd.mem_we) begin
            r_ring[i_q_cmd.addr] <= i_q_cmd.wdata;
        end
        if (o_pop && i_q_cmd.mem_re) begin
            r_rd_data <= r_ring[i_q_cmd.addr];
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_rd  <= i_q_cmd.mem_re;
            r_s1_res <= i_q_cmd.res;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    // result item
    assign o_out.valid          = r_s1_valid;
    assign o_out.accepted       = r_s1_res.accepted;
    assign o_out.sample_out     = r_s1_rd ? r_rd_data : '0;
    assign o_out.sample_valid   = r_s1_res.sample_valid;
    assign o_out.granted_frames = r_s1_res.granted_frames;
    assign o_out.underrun       = r_s1_res.underrun;
    assign o_out.fill_frames    = r_s1_res.fill_frames;
    assign o_out.half_out       = r_s1_res.half_out;

    // every popped command shows up as a result item
    a_pop_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid)
        else $error("popped command lost");

endmodule

// ===== sv/multichannel_audio_ring_fifo.sv =====
// multichannel_audio_ring_fifo: top level of the frame ring buffer
// ties together marf_front, marf_queue and marf_back; depends on marf_pkg
//
// Usage:
//   i_in carries items (write sample, period start, read sample) on a
//   valid/ready handshake; o_out returns exactly one result item per item,
//   in order. Configuration (channel_count, period_frames) is written over
//   i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
//   Each item passes through a queue entry and then the output register
//   before its result is valid on o_out.
//   Throughput: one item per cycle while the queue has room; the sample
//   memory has one port and each item makes at most one access to it.
//   The front keeps all pointers and grant state and resolves each item in
//   its accept cycle; a four-entry queue feeds the back, which owns the
//   sample memory and the output register.
//   When the receiver stalls, the output register holds, the queue fills
//   and i_in.ready drops once four items are waiting.
//   Reset clears pointers, grant, queue and output valid, sets underrun and
//   restores channel_count 2 and period_frames 1024. Sample memory is not
//   cleared; the block is ready for items as soon as reset is released.
module multichannel_audio_ring_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    marf_in_if.sink                          i_in,
    marf_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [marf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [marf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import marf_pkg::*;

    logic  q_push;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;
    t_cmd  push_cmd;
    t_cmd  head_cmd;

    // item classification and ring state
    marf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_cmd    (push_cmd)
    );

    // decoupling queue
    marf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    // memory access and result output
    marf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
